### rtl/sts_pkg.sv
package sts_pkg;

   // field widths fixed by the stream and register formats
   localparam int ANGLE_W    = 24;
   localparam int SINE_W     = 18;
   localparam int TERMS_W    = 5;
   localparam int THRESH_W   = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam int MAX_TERMS_DEFAULT = 12;

   // register index codes (byte address / 4)
   localparam logic [0:0] CSR_IDX_TERM_THRESHOLD = 1'b0;

   // range reduction: pi and 2*pi in Q16, applied in powers of two of 2*pi
   localparam int REDUCE_STEPS = 5;
   localparam int RED_K_W      = 3;
   localparam int RED_W        = 26;
   localparam logic signed [RED_W-1:0] PI_Q16     = 26'sd205887;
   localparam logic signed [RED_W-1:0] TWO_PI_Q16 = 26'sd411775;

   // datapath widths
   localparam int ABS_W   = 18;   // |x| after reduction, up to pi in Q16
   localparam int MAG_W   = 31;   // term magnitude in Q28
   localparam int X2_W    = 32;   // x*x in Q28
   localparam int PROD_W  = 64;   // mag*x2 plus rounding offset
   localparam int QRAW_W  = 34;   // rounded product over 2^28
   localparam int DIV_W   = 11;   // (2n)(2n+1)
   localparam int RECIP_W = 32;   // ceil(2^34 / D)
   localparam int EST_W   = 32;
   localparam int SUM_W   = 34;   // running sum in Q28, signed
   localparam int RECIP_SHIFT = 34;
   localparam int ROUND_Q16   = 2048;
   localparam int ONE_Q16     = 65536;

   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;

   // series divisor (2n)(2n+1), indexed by term count n
   localparam logic [DIV_W-1:0] DIV_TABLE [32] = '{
      1: 11'd6,    2: 11'd20,   3: 11'd42,   4: 11'd72,   5: 11'd110,
      6: 11'd156,  7: 11'd210,  8: 11'd272,  9: 11'd342,  10: 11'd420,
      11: 11'd506, 12: 11'd600, 13: 11'd702, 14: 11'd812, 15: 11'd930,
      16: 11'd1056, 17: 11'd1190, 18: 11'd1332, 19: 11'd1482,
      default: '0
   };

   // ceiling reciprocal of the divisor, scaled by 2^34
   localparam logic [RECIP_W-1:0] RECIP_TABLE [32] = '{
      1:  RECIP_W'((RECIP_ONE + 64'd5)    / 64'd6),
      2:  RECIP_W'((RECIP_ONE + 64'd19)   / 64'd20),
      3:  RECIP_W'((RECIP_ONE + 64'd41)   / 64'd42),
      4:  RECIP_W'((RECIP_ONE + 64'd71)   / 64'd72),
      5:  RECIP_W'((RECIP_ONE + 64'd109)  / 64'd110),
      6:  RECIP_W'((RECIP_ONE + 64'd155)  / 64'd156),
      7:  RECIP_W'((RECIP_ONE + 64'd209)  / 64'd210),
      8:  RECIP_W'((RECIP_ONE + 64'd271)  / 64'd272),
      9:  RECIP_W'((RECIP_ONE + 64'd341)  / 64'd342),
      10: RECIP_W'((RECIP_ONE + 64'd419)  / 64'd420),
      11: RECIP_W'((RECIP_ONE + 64'd505)  / 64'd506),
      12: RECIP_W'((RECIP_ONE + 64'd599)  / 64'd600),
      13: RECIP_W'((RECIP_ONE + 64'd701)  / 64'd702),
      14: RECIP_W'((RECIP_ONE + 64'd811)  / 64'd812),
      15: RECIP_W'((RECIP_ONE + 64'd929)  / 64'd930),
      16: RECIP_W'((RECIP_ONE + 64'd1055) / 64'd1056),
      17: RECIP_W'((RECIP_ONE + 64'd1189) / 64'd1190),
      18: RECIP_W'((RECIP_ONE + 64'd1331) / 64'd1332),
      19: RECIP_W'((RECIP_ONE + 64'd1481) / 64'd1482),
      default: '0
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_INIT,
      ST_MUL,
      ST_REC,
      ST_FIX,
      ST_DONE
   } sts_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic red_step;
      logic init;
      logic mul;
      logic rec;
      logic fix;
      logic out_load;
   } sts_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic red_last;
      logic more;
   } sts_status_type;

endpackage

### rtl/sine_taylor_series_unit.sv
// Sine by Taylor series in fixed point, one result beat per request beat.
// Range reduction, then one shared multiply / reciprocal / fix-up loop for each of the
// T terms used (1..MAX_TERMS). A new request is taken only after the last result is loaded.
// A finished result waits in the output register while the next request is taken.
// Reset is synchronous, active high: clears the controller, result valid and threshold.
module sine_taylor_series_unit #(
   parameter int MAX_TERMS = sts_pkg::MAX_TERMS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: [23:0] angle_radians
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sts_pkg::REQ_DATA_W-1:0]  req_tdata,
   // response: [17:0] sine_value, [22:18] terms_used, [23] zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sts_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sts_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sts_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sts_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   sts_pkg::sts_cmd_type            cmd;
   sts_pkg::sts_status_type         status;
   logic [sts_pkg::THRESH_W-1:0]    term_threshold;
   logic [sts_pkg::SINE_W-1:0]      sine_value;
   logic [sts_pkg::TERMS_W-1:0]     terms_used;

   sts_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .term_threshold (term_threshold)
   );

   sts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sts_datapath #(
      .MAX_TERMS (MAX_TERMS)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .angle_radians  (req_tdata[sts_pkg::ANGLE_W-1:0]),
      .term_threshold (term_threshold),
      .sine_value     (sine_value),
      .terms_used     (terms_used)
   );

   // pack the result beat
   assign rsp_tdata = {{(sts_pkg::RSP_DATA_W-sts_pkg::SINE_W-sts_pkg::TERMS_W){1'b0}},
                       terms_used, sine_value};

endmodule

### rtl/sts_csr.sv
module sts_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sts_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sts_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sts_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [sts_pkg::THRESH_W-1:0]     term_threshold
);

   logic [sts_pkg::THRESH_W-1:0] thresh_ff;
   logic [sts_pkg::THRESH_W-1:0] thresh_in;
   logic                         hit;

   assign hit        = (csr_paddr[2] == sts_pkg::CSR_IDX_TERM_THRESHOLD);
   assign csr_pready = 1'b1;

   // write on the access phase
   always_comb begin
      thresh_in = thresh_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         thresh_in = csr_pwdata[sts_pkg::THRESH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         sts_pkg::CSR_IDX_TERM_THRESHOLD: begin
            csr_prdata = {{(sts_pkg::CSR_DATA_W-sts_pkg::THRESH_W){1'b0}}, thresh_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign term_threshold = thresh_ff;

endmodule

### rtl/sts_ctrl.sv
module sts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  sts_pkg::sts_status_type status,
   output sts_pkg::sts_cmd_type    cmd
);

   sts_pkg::sts_state_type state_ff;
   sts_pkg::sts_state_type state_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   out_free;

   // result register can take a new beat
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sts_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = sts_pkg::ST_REDUCE;
         end
         sts_pkg::ST_REDUCE: begin
            if (status.red_last) state_in = sts_pkg::ST_INIT;
         end
         sts_pkg::ST_INIT: begin
            state_in = sts_pkg::ST_MUL;
         end
         sts_pkg::ST_MUL: begin
            state_in = status.more ? sts_pkg::ST_REC : sts_pkg::ST_DONE;
         end
         sts_pkg::ST_REC: begin
            state_in = sts_pkg::ST_FIX;
         end
         sts_pkg::ST_FIX: begin
            state_in = sts_pkg::ST_MUL;
         end
         sts_pkg::ST_DONE: begin
            if (out_free) state_in = sts_pkg::ST_IDLE;
         end
         default: begin
            state_in = sts_pkg::ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         sts_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         sts_pkg::ST_REDUCE: begin
            cmd.red_step = 1'b1;
         end
         sts_pkg::ST_INIT: begin
            cmd.init = 1'b1;
         end
         sts_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
         end
         sts_pkg::ST_REC: begin
            cmd.rec = 1'b1;
         end
         sts_pkg::ST_FIX: begin
            cmd.fix = 1'b1;
         end
         sts_pkg::ST_DONE: begin
            cmd.out_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // result beat flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sts_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### rtl/sts_datapath.sv
module sts_datapath #(
   parameter int MAX_TERMS = sts_pkg::MAX_TERMS_DEFAULT
) (
   input  logic                            clock,
   input  sts_pkg::sts_cmd_type            cmd,
   output sts_pkg::sts_status_type         status,
   input  logic [sts_pkg::ANGLE_W-1:0]     angle_radians,
   input  logic [sts_pkg::THRESH_W-1:0]    term_threshold,
   output logic [sts_pkg::SINE_W-1:0]      sine_value,
   output logic [sts_pkg::TERMS_W-1:0]     terms_used
);

   localparam int RW = sts_pkg::RED_W;

   // angle and reduction step
   logic signed [sts_pkg::ANGLE_W-1:0] x_ff, x_in;
   logic [sts_pkg::RED_K_W-1:0]        red_k_ff, red_k_in;
   // series state
   logic [sts_pkg::MAG_W-1:0]          mag_ff, mag_in;
   logic [sts_pkg::X2_W-1:0]           x2_ff, x2_in;
   logic                               neg_ff, neg_in;
   logic signed [sts_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [sts_pkg::TERMS_W-1:0]        terms_ff, terms_in;
   logic [sts_pkg::QRAW_W-1:0]         qraw_ff, qraw_in;
   logic [sts_pkg::EST_W-1:0]          est_ff, est_in;
   // result register
   logic [sts_pkg::SINE_W-1:0]         sine_ff, sine_in;
   logic [sts_pkg::TERMS_W-1:0]        tout_ff, tout_in;

   logic signed [RW-1:0]               x_ext, step_c, cand;
   logic                               take;
   logic [sts_pkg::ABS_W-1:0]          ax;
   logic [2*sts_pkg::ABS_W-1:0]        sq;
   logic [sts_pkg::DIV_W-1:0]          dval;
   logic [sts_pkg::RECIP_W-1:0]        recip;
   logic [sts_pkg::PROD_W-1:0]         mac;
   logic [sts_pkg::QRAW_W+sts_pkg::RECIP_W-1:0] est_prod;
   logic [sts_pkg::EST_W+sts_pkg::DIV_W-1:0]    ed;
   logic                               over;
   logic [sts_pkg::MAG_W-1:0]          limit;
   logic [sts_pkg::SUM_W-1:0]          s_abs, s_rnd;
   logic [sts_pkg::SUM_W-13:0]         q16;
   logic [sts_pkg::SINE_W-2:0]         q_sat;

   // per-term constants
   assign dval  = sts_pkg::DIV_TABLE[terms_ff];
   assign recip = sts_pkg::RECIP_TABLE[terms_ff];

   // reduction: step 2^k * 2pi toward zero unless that overshoots past -pi or pi
   always_comb begin
      x_ext  = {{(RW-sts_pkg::ANGLE_W){x_ff[sts_pkg::ANGLE_W-1]}}, x_ff};
      step_c = sts_pkg::TWO_PI_Q16 <<< red_k_ff;
      if (x_ff[sts_pkg::ANGLE_W-1]) begin
         cand = x_ext + step_c;
         take = (cand <= sts_pkg::PI_Q16);
      end else begin
         cand = x_ext - step_c;
         take = (cand >= -sts_pkg::PI_Q16);
      end
   end

   // first term and x squared
   assign ax = x_ff[sts_pkg::ANGLE_W-1] ? sts_pkg::ABS_W'(-x_ff)
                                        : x_ff[sts_pkg::ABS_W-1:0];
   assign sq = ax * ax;

   // term step: mag*x2 plus half divisor, then reciprocal estimate, then fix-up
   assign mac      = ({1'b0, mag_ff} * x2_ff)
                   + (sts_pkg::PROD_W'(dval) << (sts_pkg::RECIP_SHIFT - 7));
   assign est_prod = qraw_ff * recip;
   assign ed       = est_ff * dval;
   assign over     = ({{sts_pkg::DIV_W-2{1'b0}}, qraw_ff} < ed);

   // stop test
   assign limit       = {{(sts_pkg::MAG_W-sts_pkg::THRESH_W-12){1'b0}}, term_threshold, 12'd0};
   assign status.more = (terms_ff < sts_pkg::TERMS_W'(MAX_TERMS)) && (mag_ff > limit);
   assign status.red_last = (red_k_ff == '0);

   // Q28 sum to Q16, ties away from zero, clamp to one
   always_comb begin
      s_abs = sum_ff[sts_pkg::SUM_W-1] ? sts_pkg::SUM_W'(-sum_ff) : sts_pkg::SUM_W'(sum_ff);
      s_rnd = s_abs + sts_pkg::SUM_W'(sts_pkg::ROUND_Q16);
      q16   = s_rnd[sts_pkg::SUM_W-1:12];
      if (q16 > (sts_pkg::SUM_W-12)'(sts_pkg::ONE_Q16)) begin
         q_sat = (sts_pkg::SINE_W-1)'(sts_pkg::ONE_Q16);
      end else begin
         q_sat = q16[sts_pkg::SINE_W-2:0];
      end
   end

   // register updates
   always_comb begin
      x_in     = x_ff;
      red_k_in = red_k_ff;
      mag_in   = mag_ff;
      x2_in    = x2_ff;
      neg_in   = neg_ff;
      sum_in   = sum_ff;
      terms_in = terms_ff;
      qraw_in  = qraw_ff;
      est_in   = est_ff;
      sine_in  = sine_ff;
      tout_in  = tout_ff;
      if (cmd.load) begin
         x_in     = angle_radians;
         red_k_in = sts_pkg::RED_K_W'(sts_pkg::REDUCE_STEPS - 1);
      end
      if (cmd.red_step) begin
         if (take) x_in = cand[sts_pkg::ANGLE_W-1:0];
         red_k_in = red_k_ff - 1'b1;
      end
      if (cmd.init) begin
         mag_in   = {{(sts_pkg::MAG_W-sts_pkg::ABS_W-12){1'b0}}, ax, 12'd0};
         x2_in    = sq[sts_pkg::X2_W+3:4];
         neg_in   = x_ff[sts_pkg::ANGLE_W-1];
         sum_in   = '0;
         terms_in = sts_pkg::TERMS_W'(1);
      end
      if (cmd.mul) begin
         sum_in  = neg_ff ? sum_ff - sts_pkg::SUM_W'(mag_ff) : sum_ff + sts_pkg::SUM_W'(mag_ff);
         qraw_in = mac[sts_pkg::QRAW_W+27:28];
      end
      if (cmd.rec) begin
         est_in = est_prod[sts_pkg::QRAW_W+sts_pkg::RECIP_W-1:sts_pkg::RECIP_SHIFT];
      end
      if (cmd.fix) begin
         mag_in   = sts_pkg::MAG_W'(est_ff - sts_pkg::EST_W'(over));
         neg_in   = !neg_ff;
         terms_in = terms_ff + 1'b1;
      end
      if (cmd.out_load) begin
         sine_in = sum_ff[sts_pkg::SUM_W-1] ? sts_pkg::SINE_W'(-{1'b0, q_sat})
                                            : {1'b0, q_sat};
         tout_in = terms_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      red_k_ff <= red_k_in;
      mag_ff   <= mag_in;
      x2_ff    <= x2_in;
      neg_ff   <= neg_in;
      sum_ff   <= sum_in;
      terms_ff <= terms_in;
      qraw_ff  <= qraw_in;
      est_ff   <= est_in;
      sine_ff  <= sine_in;
      tout_ff  <= tout_in;
   end

   assign sine_value = sine_ff;
   assign terms_used = tout_ff;

endmodule

### test/tb_sine_taylor_series_unit.sv
module tb_sine_taylor_series_unit;

   localparam int SERIES_TERMS = sts_pkg::MAX_TERMS_DEFAULT;
   localparam longint ANGLE_PI     = 205887;
   localparam longint ANGLE_TWO_PI = 411775;
   // drain time after the last result, scaled with the series length plus a margin
   localparam int DRAIN_CYCLES = 3 * SERIES_TERMS + 12;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_PER_PHASE = 190;
   // any index other than the threshold's is out of range
   localparam logic [0:0] CSR_IDX_SPARE = 1'b1;

   typedef struct {
      logic signed [sts_pkg::ANGLE_W-1:0] angle;
      logic signed [sts_pkg::SINE_W-1:0]  sine;
      logic [sts_pkg::TERMS_W-1:0]        terms;
   } sine_expect_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [sts_pkg::REQ_DATA_W-1:0]  req_tdata = '0;  // [23:0] angle_radians
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // [17:0] sine_value, [22:18] terms_used, [23] pad
   logic [sts_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [sts_pkg::CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [sts_pkg::CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [sts_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                            csr_pready;

   sine_expect_type pending_sines[$];
   logic [sts_pkg::THRESH_W-1:0] term_threshold_q = '0;
   int mismatches = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_span = 0;

   sine_taylor_series_unit #(
      .MAX_TERMS (SERIES_TERMS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // fixed-point Taylor sum of sin(angle), Q28 terms, Q16 result
   function automatic sine_expect_type taylor_sine(
      logic signed [sts_pkg::ANGLE_W-1:0] angle,
      logic [sts_pkg::THRESH_W-1:0] thresh);
      sine_expect_type res;
      longint x;
      longint unsigned ax, mag, x2, lim, dv;
      longint acc, s;
      bit neg;
      int unsigned terms, n;
      x = angle;
      while (x < -ANGLE_PI) x += ANGLE_TWO_PI;
      while (x > ANGLE_PI) x -= ANGLE_TWO_PI;
      neg = x < 0;
      ax = neg ? -x : x;
      mag = ax << 12;
      x2 = (ax * ax) >> 4;
      acc = neg ? -$signed(mag) : $signed(mag);
      lim = thresh;
      lim = lim << 12;
      terms = 1;
      n = 1;
      while (terms < SERIES_TERMS && mag > lim) begin
         dv = (2 * n) * (2 * n + 1);
         dv = dv << 28;
         mag = (mag * x2 + (dv >> 1)) / dv;
         neg = !neg;
         acc = acc + (neg ? -$signed(mag) : $signed(mag));
         terms++;
         n++;
      end
      // round to Q16, ties away from zero, then clamp to +-1
      if (acc >= 0)
         s = (acc + 2048) >>> 12;
      else
         s = -((-acc + 2048) >>> 12);
      if (s > sts_pkg::ONE_Q16) s = sts_pkg::ONE_Q16;
      if (s < -sts_pkg::ONE_Q16) s = -sts_pkg::ONE_Q16;
      res.angle = angle;
      res.sine  = s[sts_pkg::SINE_W-1:0];
      res.terms = terms[sts_pkg::TERMS_W-1:0];
      return res;
   endfunction

   // spread over full range, one period, tiny values and near multiples of pi
   function automatic logic signed [sts_pkg::ANGLE_W-1:0] random_angle();
      int v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = int'($urandom_range(0, 2 * ANGLE_PI)) - int'(ANGLE_PI);
         2: v = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 4096));
         default: v = (int'($urandom_range(0, 40)) - 20) * int'(ANGLE_PI)
                      + int'($urandom_range(0, 64)) - 32;
      endcase
      return v[sts_pkg::ANGLE_W-1:0];
   endfunction

   // one request beat; bursts of random length with random gaps between them
   task automatic send_angle(logic signed [sts_pkg::ANGLE_W-1:0] angle);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= angle;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_sines.push_back(taylor_sine(angle, term_threshold_q));
   endtask

   // drop valid, let every result arrive, then let the unit settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_sines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // setup and access phase of one register write, then the bus returns to idle
   task automatic csr_write(logic [0:0] idx, logic [sts_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == sts_pkg::CSR_IDX_TERM_THRESHOLD)
         term_threshold_q = value[sts_pkg::THRESH_W-1:0];
      @(posedge clock);
   endtask

   // threshold left at its reset value: field extremes, pi edges, wrap-round
   task automatic test_reset_threshold();
      logic signed [sts_pkg::ANGLE_W-1:0] edge_angles[13];
      edge_angles = '{24'sd0, 24'sd1, -24'sd1, 24'sh7FFFFF, 24'sh800000,
                      24'sd205887, -24'sd205887, 24'sd205888, -24'sd205888,
                      24'sd411775, 24'sd102944, -24'sd102944, 24'sd65536};
      foreach (edge_angles[i]) send_angle(edge_angles[i]);
   endtask

   // largest threshold: first term alone, early stop with a partial sum
   task automatic test_threshold_extremes();
      wait_idle();
      csr_write(sts_pkg::CSR_IDX_TERM_THRESHOLD, 32'd65535);
      send_angle(24'sd65535);
      send_angle(24'sd65536);
      send_angle(24'sd205887);
      send_angle(-24'sd205887);
      send_angle(24'sd0);
      send_angle(24'sh7FFFFF);
   endtask

   // a write to an unused index must leave the threshold alone
   task automatic test_unused_index();
      wait_idle();
      csr_write(sts_pkg::CSR_IDX_TERM_THRESHOLD, 32'd300);
      csr_write(CSR_IDX_SPARE, 32'hFFFF_FFFF);
      send_angle(24'sd150000);
      send_angle(-24'sd40000);
      send_angle(24'sd1200);
      send_angle(24'sh800000);
   endtask

   // random angles under a sweep of thresholds
   task automatic test_random_sweep();
      logic [sts_pkg::CSR_DATA_W-1:0] limits[6];
      limits = '{32'd0, 32'd65535, 32'd1, 32'($urandom_range(0, 65535)),
                 32'($urandom_range(0, 63)), 32'd4096};
      foreach (limits[p]) begin
         wait_idle();
         csr_write(sts_pkg::CSR_IDX_TERM_THRESHOLD, limits[p]);
         repeat (RANDOM_PER_PHASE) send_angle(random_angle());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_threshold();
      test_threshold_extremes();
      test_unused_index();
      test_random_sweep();
      wait_idle();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // result beats against the oldest prediction
   always @(posedge clock) begin : check_results
      sine_expect_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_sines.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with none expected: sine %0d terms %0d", $time,
                     $signed(rsp_tdata[sts_pkg::SINE_W-1:0]),
                     rsp_tdata[sts_pkg::SINE_W +: sts_pkg::TERMS_W]);
         end else begin
            want = pending_sines.pop_front();
            if (rsp_tdata[sts_pkg::SINE_W-1:0] !== want.sine) begin
               mismatches++;
               $display("%0t: angle %0d sine expected %0d actual %0d", $time, want.angle,
                        want.sine, $signed(rsp_tdata[sts_pkg::SINE_W-1:0]));
            end
            if (rsp_tdata[sts_pkg::SINE_W +: sts_pkg::TERMS_W] !== want.terms) begin
               mismatches++;
               $display("%0t: angle %0d terms expected %0d actual %0d", $time, want.angle,
                        want.terms, rsp_tdata[sts_pkg::SINE_W +: sts_pkg::TERMS_W]);
            end
         end
      end
   end

   // receiver back-pressure: modes change after random spans
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_span <= $urandom_range(20, 300);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= stall_span[2];
      endcase
   end

   // watchdog: too long without any beat or register access
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

### sine_taylor_series_unit.f
rtl/sts_pkg.sv
rtl/sts_csr.sv
rtl/sts_ctrl.sv
rtl/sts_datapath.sv
rtl/sine_taylor_series_unit.sv
test/tb_sine_taylor_series_unit.sv
